// ===== design/hng_pkg.sv =====
// Shared types and constants of the height-map normal generator.
// Used by every module of the block but hng_ram; depends on nothing else.
`timescale 1ns / 1ps

package hng_pkg;

    // Geometry and field widths.
    localparam int MAX_ROW_LENGTH = 1024;
    localparam int COL_W          = $clog2(MAX_ROW_LENGTH);
    localparam int LEN_W          = COL_W + 1;
    localparam int ROW_W          = 16;
    localparam int SCALE_W        = 16;
    localparam int SAMPLE_W       = 8;
    localparam int DIFF_W         = SAMPLE_W + 1;
    localparam int HEIGHT_W       = 16;
    localparam int NORMAL_W       = 16;
    localparam int S_TDATA_W      = 8;
    localparam int M_TDATA_W      = 96;

    // Arithmetic widths of the normal datapath.
    localparam int MAG_W   = SAMPLE_W + SCALE_W;   // |diff| * scale
    localparam int SUM_W   = 50;                   // p*p + q*q + K*K, even for the root
    localparam int ROOT_W  = SUM_W / 2;
    localparam int SREM_W  = ROOT_W + 2;
    localparam int NUM_W   = 40;                   // dividend of the component divider
    localparam int QUOT_W  = 17;
    localparam int DREM_W  = ROOT_W;
    localparam int ITER_W  = 5;
    localparam int SQRT_STEPS = ROOT_W;
    localparam int DIV_STEPS  = QUOT_W;

    // Normal constant K = 2 * 255 * 256 and its square.
    localparam logic [16:0]      NORM_K    = 17'd130560;
    localparam logic [SUM_W-1:0] NORM_K_SQ = 50'd17045913600;
    localparam logic [15:0]      NORM_ONE  = 16'h7FFF;
    localparam logic [6:0]       HEIGHT_ROUND   = 7'd127;

    // Division by 255 as a multiplication by ceil(2^32 / 255); exact for
    // every dividend below 2^24.
    localparam int                      HEIGHT_RECIP_W = 25;
    localparam logic [HEIGHT_RECIP_W-1:0] HEIGHT_RECIP = 25'd16843010;
    localparam int                      HEIGHT_SHIFT   = 32;

    // Configuration register indexes and reset values.
    localparam logic [1:0] REG_ROW_LENGTH   = 2'd0;
    localparam logic [1:0] REG_ROW_COUNT    = 2'd1;
    localparam logic [1:0] REG_HEIGHT_SCALE = 2'd2;
    localparam int         CFG_DATA_W       = 16;
    localparam logic [LEN_W-1:0]   ROW_LENGTH_RESET   = 11'd256;
    localparam logic [ROW_W-1:0]   ROW_COUNT_RESET    = 16'd256;
    localparam logic [SCALE_W-1:0] HEIGHT_SCALE_RESET = 16'd256;
    localparam int                 MIN_DIM            = 3;

    // Divider destinations.
    localparam logic [1:0] DSEL_X      = 2'd1;
    localparam logic [1:0] DSEL_Y      = 2'd2;
    localparam logic [1:0] DSEL_Z      = 2'd3;

    // One queued sample with everything the back end needs.
    typedef struct packed {
        logic [COL_W-1:0]          x;
        logic [ROW_W-1:0]          y;
        logic                      emit_a;    // result for the row above
        logic                      emit_b;    // own border result in the last row
        logic                      border_a;
        logic [SAMPLE_W-1:0]       h_a;
        logic [SAMPLE_W-1:0]       h_b;
        logic signed [DIFF_W-1:0]  dx;        // left - right
        logic signed [DIFF_W-1:0]  dz;        // up - down
    } job_t;

    typedef enum logic [1:0] {
        F_IDLE,
        F_RD_CENTER,
        F_RD_SIDES,
        F_PUSH
    } front_state_t;

    typedef enum logic [3:0] {
        B_IDLE,
        B_HEIGHT,
        B_HEIGHT_DIV,
        B_MAG,
        B_SQ_P,
        B_SQ_Q,
        B_SUM,
        B_ROOT,
        B_DIV_SET,
        B_DIV,
        B_OUT
    } back_state_t;

endpackage

// ===== design/heightmap_normal_generator_core.sv =====
// Height-map normal generator. Takes 8-bit height samples in raster order and
// returns, one row later, the column, row, scaled height (Q8.8) and Q1.15 unit
// normal of each vertex; samples of the last row also return their own border
// result. The front end takes each sample through accept, two line-buffer
// reads and write-back; the back end takes a job from the queue, computes the
// height and, for an interior result only, runs the 25-step square root and
// the 17-step divider once per normal component. A two-entry job queue lets
// both ends stall independently. Uses hng_pkg, hng_front, hng_queue, hng_back.
`timescale 1ns / 1ps

module heightmap_normal_generator_core (
    input  logic                          aclk,
    input  logic                          aresetn,
    // s_tdata: height_sample[7:0]
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [hng_pkg::S_TDATA_W-1:0] s_tdata,
    // m_tdata: column[9:0], row[25:10], vertex_height[41:26], normal_x[57:42],
    // normal_y[73:58], normal_z[89:74], zero fill[95:90]
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [hng_pkg::M_TDATA_W-1:0] m_tdata,
    output logic                          m_tlast,
    input  logic                          cfg_wr_en,
    input  logic [1:0]                    cfg_index,
    input  logic [hng_pkg::CFG_DATA_W-1:0] cfg_wdata
);
    import hng_pkg::*;

    logic [LEN_W-1:0]   row_length_reg;
    logic [ROW_W-1:0]   row_count_reg;
    logic [SCALE_W-1:0] height_scale_reg;
    logic [LEN_W-1:0]   len_eff;
    logic [ROW_W-1:0]   rows_eff;
    logic               push;
    logic               full;
    logic               pop;
    logic               empty;
    job_t               job_in;
    job_t               job_out;

    // Configuration registers; an unused index is ignored.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_length_reg   <= ROW_LENGTH_RESET;
            row_count_reg    <= ROW_COUNT_RESET;
            height_scale_reg <= HEIGHT_SCALE_RESET;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_ROW_LENGTH:   row_length_reg   <= cfg_wdata[LEN_W-1:0];
                REG_ROW_COUNT:    row_count_reg    <= cfg_wdata[ROW_W-1:0];
                REG_HEIGHT_SCALE: height_scale_reg <= cfg_wdata[SCALE_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Clamp the frame size to the supported range.
    always_comb begin
        priority if (row_length_reg < LEN_W'(MIN_DIM))        len_eff = LEN_W'(MIN_DIM);
        else if (row_length_reg > LEN_W'(MAX_ROW_LENGTH))     len_eff = LEN_W'(MAX_ROW_LENGTH);
        else                                                  len_eff = row_length_reg;
        rows_eff = (row_count_reg < ROW_W'(MIN_DIM)) ? ROW_W'(MIN_DIM) : row_count_reg;
    end

    hng_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .len_i    (len_eff),
        .rows_i   (rows_eff),
        .push_o   (push),
        .job_o    (job_in),
        .full_i   (full)
    );

    hng_queue u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push_i  (push),
        .job_i   (job_in),
        .full_o  (full),
        .pop_i   (pop),
        .job_o   (job_out),
        .empty_o (empty)
    );

    hng_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .empty_i  (empty),
        .job_i    (job_out),
        .pop_o    (pop),
        .scale_i  (height_scale_reg),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

endmodule

// ===== design/hng_ram.sv =====
// Generic simple dual-port RAM with one write port and a registered read port.
// Standalone; used for the line buffers of the front end.
`timescale 1ns / 1ps

module hng_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     we_i,
    input  logic [$clog2(DEPTH)-1:0] waddr_i,
    input  logic [WIDTH-1:0]         wdata_i,
    input  logic [$clog2(DEPTH)-1:0] raddr_i,
    output logic [WIDTH-1:0]         rdata_o
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write and registered read.
    always_ff @(posedge aclk) begin
        if (we_i) begin
            mem_reg[waddr_i] <= wdata_i;
        end
        rdata_reg <= mem_reg[raddr_i];
    end

    assign rdata_o = rdata_reg;

endmodule

// ===== design/hng_front.sv =====
// Front end: accepts height samples, tracks the raster position, reads and
// updates the two line buffers and builds one job per sample. Uses hng_pkg, hng_ram.
`timescale 1ns / 1ps

module hng_front (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [hng_pkg::S_TDATA_W-1:0] s_tdata,
    input  logic [hng_pkg::LEN_W-1:0]   len_i,
    input  logic [hng_pkg::ROW_W-1:0]   rows_i,
    output logic                        push_o,
    output hng_pkg::job_t               job_o,
    input  logic                        full_i
);
    import hng_pkg::*;

    front_state_t state_reg, state_next;

    logic [COL_W-1:0]    col_reg;
    logic [ROW_W-1:0]    row_reg;
    logic [COL_W-1:0]    x_reg;
    logic [ROW_W-1:0]    y_reg;
    logic [SAMPLE_W-1:0] h_reg;
    logic [SAMPLE_W-1:0] center_reg;
    logic [SAMPLE_W-1:0] up_reg;
    logic [SAMPLE_W-1:0] left_reg;
    logic [SAMPLE_W-1:0] right_reg;

    logic                accept;
    logic                col_wrap;
    logic                row_wrap;
    logic                has_result;
    logic                advance;
    logic                ram_we;
    logic [COL_W-1:0]    prev_raddr;
    logic [COL_W-1:0]    older_raddr;
    logic [SAMPLE_W-1:0] prev_rdata;
    logic [SAMPLE_W-1:0] older_rdata;
    logic [ROW_W:0]      y_plus;

    // Position wrap of the sample being accepted.
    assign col_wrap = ({1'b0, col_reg} + LEN_W'(1)) >= len_i;
    assign row_wrap = ({1'b0, row_reg} + 17'd1) >= {1'b0, rows_i};

    // Job built from the captured sample and its neighbors.
    assign y_plus            = {1'b0, y_reg} + 17'd1;
    assign job_o.x           = x_reg;
    assign job_o.y           = y_reg;
    assign job_o.emit_a      = (y_reg != '0);
    assign job_o.emit_b      = y_plus >= {1'b0, rows_i};
    assign job_o.border_a    = (x_reg == '0)
                            || (({1'b0, x_reg} + LEN_W'(1)) >= len_i)
                            || (y_reg == ROW_W'(1))
                            || (y_reg >= rows_i);
    assign job_o.h_a         = center_reg;
    assign job_o.h_b         = h_reg;
    assign job_o.dx          = $signed({1'b0, left_reg}) - $signed({1'b0, right_reg});
    assign job_o.dz          = $signed({1'b0, up_reg}) - $signed({1'b0, h_reg});
    assign has_result        = job_o.emit_a || job_o.emit_b;
    assign advance           = !has_result || !full_i;

    // Next state.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            F_IDLE:      if (s_tvalid) state_next = F_RD_CENTER;
            F_RD_CENTER: state_next = F_RD_SIDES;
            F_RD_SIDES:  state_next = F_PUSH;
            F_PUSH:      if (advance) state_next = F_IDLE;
            default:     state_next = F_IDLE;
        endcase
    end

    // Handshake, buffer addressing and queue push.
    always_comb begin
        s_tready    = 1'b0;
        push_o      = 1'b0;
        ram_we      = 1'b0;
        prev_raddr  = x_reg;
        older_raddr = x_reg;
        unique case (state_reg)
            F_IDLE: begin
                s_tready    = 1'b1;
                prev_raddr  = col_reg;
                older_raddr = col_reg;
            end
            F_RD_CENTER: begin
                prev_raddr  = x_reg + COL_W'(1);
                older_raddr = x_reg - COL_W'(1);
            end
            F_RD_SIDES: begin
            end
            F_PUSH: begin
                push_o = has_result && !full_i;
                ram_we = advance;
            end
            default: begin
            end
        endcase
    end

    assign accept = s_tvalid && s_tready;

    // State and position counters.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= F_IDLE;
            col_reg   <= '0;
            row_reg   <= '0;
        end else begin
            state_reg <= state_next;
            if (accept) begin
                if (col_wrap) begin
                    col_reg <= '0;
                    row_reg <= row_wrap ? '0 : row_reg + ROW_W'(1);
                end else begin
                    col_reg <= col_reg + COL_W'(1);
                end
            end
        end
    end

    // Captured sample and neighbor values.
    always_ff @(posedge aclk) begin
        if (accept) begin
            x_reg <= col_reg;
            y_reg <= row_reg;
            h_reg <= s_tdata[SAMPLE_W-1:0];
        end
        if (state_reg == F_RD_CENTER) begin
            center_reg <= prev_rdata;
            up_reg     <= older_rdata;
        end
        if (state_reg == F_RD_SIDES) begin
            right_reg <= prev_rdata;
            left_reg  <= older_rdata;
        end
    end

    // Line buffer of the previous row.
    hng_ram #(.WIDTH(SAMPLE_W), .DEPTH(MAX_ROW_LENGTH)) u_prev_row (
        .aclk    (aclk),
        .we_i    (ram_we),
        .waddr_i (x_reg),
        .wdata_i (h_reg),
        .raddr_i (prev_raddr),
        .rdata_o (prev_rdata)
    );

    // Line buffer of the row before that.
    hng_ram #(.WIDTH(SAMPLE_W), .DEPTH(MAX_ROW_LENGTH)) u_older_row (
        .aclk    (aclk),
        .we_i    (ram_we),
        .waddr_i (x_reg),
        .wdata_i (center_reg),
        .raddr_i (older_raddr),
        .rdata_o (older_rdata)
    );

    // Only jobs that carry results reach the queue.
    assert property (@(posedge aclk) disable iff (!aresetn)
        push_o |-> (job_o.emit_a || job_o.emit_b))
        else $error("front pushed a job without results");

endmodule

// ===== design/hng_queue.sv =====
// Two-entry job queue between front and back end.
// Uses hng_pkg for the job type.
`timescale 1ns / 1ps

module hng_queue (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          push_i,
    input  hng_pkg::job_t job_i,
    output logic          full_o,
    input  logic          pop_i,
    output hng_pkg::job_t job_o,
    output logic          empty_o
);
    import hng_pkg::*;

    job_t       mem_reg [2];
    logic       wptr_reg;
    logic       rptr_reg;
    logic [1:0] count_reg;
    logic       do_push;
    logic       do_pop;

    assign full_o  = (count_reg == 2'd2);
    assign empty_o = (count_reg == 2'd0);
    assign do_push = push_i && !full_o;
    assign do_pop  = pop_i && !empty_o;
    assign job_o   = mem_reg[rptr_reg];

    // Pointers and fill count.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wptr_reg  <= 1'b0;
            rptr_reg  <= 1'b0;
            count_reg <= 2'd0;
        end else begin
            if (do_push) wptr_reg <= !wptr_reg;
            if (do_pop)  rptr_reg <= !rptr_reg;
            count_reg <= count_reg + {1'b0, do_push} - {1'b0, do_pop};
        end
    end

    // Entry storage.
    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wptr_reg] <= job_i;
        end
    end

    assert property (@(posedge aclk) disable iff (!aresetn) push_i |-> !full_o)
        else $error("job pushed into a full queue");
    assert property (@(posedge aclk) disable iff (!aresetn) pop_i |-> !empty_o)
        else $error("job popped from an empty queue");
    assert property (@(posedge aclk) disable iff (!aresetn) count_reg != 2'd3)
        else $error("queue fill count out of range");

endmodule

// ===== design/hng_back.sv =====
// Back end: turns a job into one or two results, computing the scaled height
// by a reciprocal multiplication and, for an interior result only, the unit
// normal with an iterative square root and an iterative divider. Uses hng_pkg.
`timescale 1ns / 1ps

module hng_back (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          empty_i,
    input  hng_pkg::job_t                 job_i,
    output logic                          pop_o,
    input  logic [hng_pkg::SCALE_W-1:0]   scale_i,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [hng_pkg::M_TDATA_W-1:0] m_tdata,
    output logic                          m_tlast
);
    import hng_pkg::*;

    back_state_t state_reg, state_next;

    job_t                 job_reg;
    logic                 cur_b_reg;
    logic [ITER_W-1:0]    iter_reg;
    logic [1:0]           dsel_reg;
    logic [MAG_W-1:0]     p_mag_reg;
    logic [MAG_W-1:0]     q_mag_reg;
    logic [2*MAG_W-1:0]   sq_p_reg;
    logic [2*MAG_W-1:0]   sq_q_reg;
    logic [SUM_W-1:0]     rad_reg;
    logic [ROOT_W-1:0]    root_reg;
    logic [SREM_W-1:0]    srem_reg;
    logic [DREM_W-1:0]    drem_reg;
    logic [QUOT_W-1:0]    dnum_reg;
    logic [QUOT_W-1:0]    quot_reg;
    logic [ROOT_W-1:0]    den_reg;
    logic [MAG_W-1:0]     height_num_reg;
    logic [HEIGHT_W-1:0]  height_reg;
    logic [NORMAL_W-1:0]  nx_reg;
    logic [NORMAL_W-1:0]  ny_reg;
    logic [NORMAL_W-1:0]  nz_reg;

    logic [SAMPLE_W-1:0]  h_cur;
    logic                 border_cur;
    logic [SAMPLE_W-1:0]  abs_dx;
    logic [SAMPLE_W-1:0]  abs_dz;
    logic [SREM_W+1:0]    sq_t;
    logic [SREM_W+1:0]    sq_trial;
    logic                 sq_ge;
    logic [DREM_W:0]      div_t;
    logic                 div_ge;
    logic [QUOT_W-1:0]    quot_full;
    logic [NORMAL_W-1:0]  comp_sat;
    logic [NORMAL_W-1:0]  comp_signed;
    logic                 comp_neg;
    logic [MAG_W-1:0]     comp_mag;
    logic [MAG_W-1:0]     height_num;
    logic [MAG_W+HEIGHT_RECIP_W-1:0] height_prod;
    logic [NUM_W-1:0]     comp_num;
    logic                 sqrt_last;
    logic                 div_last;
    logic [ROW_W-1:0]     row_out;

    assign h_cur      = cur_b_reg ? job_reg.h_b : job_reg.h_a;
    assign border_cur = cur_b_reg || job_reg.border_a;
    assign abs_dx     = job_reg.dx[DIFF_W-1] ? SAMPLE_W'(-job_reg.dx) : job_reg.dx[SAMPLE_W-1:0];
    assign abs_dz     = job_reg.dz[DIFF_W-1] ? SAMPLE_W'(-job_reg.dz) : job_reg.dz[SAMPLE_W-1:0];
    assign sqrt_last  = (iter_reg == ITER_W'(SQRT_STEPS - 1));
    assign div_last   = (iter_reg == ITER_W'(DIV_STEPS - 1));

    // One step of the digit-by-digit square root.
    assign sq_t     = {srem_reg, rad_reg[SUM_W-1 -: 2]};
    assign sq_trial = {2'b00, root_reg, 2'b01};
    assign sq_ge    = sq_t >= sq_trial;

    // One step of the restoring divider.
    assign div_t     = {drem_reg, dnum_reg[QUOT_W-1]};
    assign div_ge    = div_t >= {1'b0, den_reg};
    assign quot_full = {quot_reg[QUOT_W-2:0], div_ge};

    // Saturation and sign of a normal component.
    assign comp_sat    = (quot_full[QUOT_W-1] || quot_full[NORMAL_W-1]) ?
                         NORM_ONE : quot_full[NORMAL_W-1:0];
    assign comp_neg    = ((dsel_reg == DSEL_X) && job_reg.dx[DIFF_W-1])
                      || ((dsel_reg == DSEL_Z) && job_reg.dz[DIFF_W-1]);
    assign comp_signed = comp_neg ? -comp_sat : comp_sat;

    // Rounded height dividend, then its quotient by 255 through the reciprocal.
    assign height_num  = h_cur * scale_i + MAG_W'(HEIGHT_ROUND);
    assign height_prod = height_num_reg * HEIGHT_RECIP;

    // Rounded dividend of a normal component.
    always_comb begin
        priority if (dsel_reg == DSEL_X) comp_mag = p_mag_reg;
        else if (dsel_reg == DSEL_Z)     comp_mag = q_mag_reg;
        else                             comp_mag = MAG_W'(NORM_K);
    end
    assign comp_num = {1'b0, comp_mag, 15'd0} + NUM_W'(root_reg[ROOT_W-1:1]);

    // Next state.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            B_IDLE:       if (!empty_i) state_next = B_HEIGHT;
            B_HEIGHT:     state_next = B_HEIGHT_DIV;
            B_HEIGHT_DIV: state_next = border_cur ? B_OUT : B_MAG;
            B_MAG:        state_next = B_SQ_P;
            B_SQ_P:       state_next = B_SQ_Q;
            B_SQ_Q:       state_next = B_SUM;
            B_SUM:        state_next = B_ROOT;
            B_ROOT:       if (sqrt_last) state_next = B_DIV_SET;
            B_DIV_SET:    state_next = B_DIV;
            B_DIV: begin
                if (div_last) begin
                    state_next = (dsel_reg == DSEL_Z) ? B_OUT : B_DIV_SET;
                end
            end
            B_OUT: begin
                if (m_tready) begin
                    state_next = (!cur_b_reg && job_reg.emit_b) ? B_HEIGHT : B_IDLE;
                end
            end
            default: state_next = B_IDLE;
        endcase
    end

    // Handshake outputs.
    always_comb begin
        pop_o    = 1'b0;
        m_tvalid = 1'b0;
        unique case (state_reg)
            B_IDLE:  pop_o    = !empty_i;
            B_OUT:   m_tvalid = 1'b1;
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= B_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Datapath registers.
    always_ff @(posedge aclk) begin
        unique case (state_reg)
            B_IDLE: begin
                if (!empty_i) begin
                    job_reg   <= job_i;
                    cur_b_reg <= !job_i.emit_a;
                end
            end
            B_HEIGHT: height_num_reg <= height_num;
            B_HEIGHT_DIV: begin
                height_reg <= height_prod[HEIGHT_SHIFT +: HEIGHT_W];
                nx_reg     <= '0;
                ny_reg     <= NORM_ONE;
                nz_reg     <= '0;
            end
            B_MAG: begin
                p_mag_reg <= abs_dx * scale_i;
                q_mag_reg <= abs_dz * scale_i;
            end
            B_SQ_P: sq_p_reg <= p_mag_reg * p_mag_reg;
            B_SQ_Q: sq_q_reg <= q_mag_reg * q_mag_reg;
            B_SUM: begin
                rad_reg  <= SUM_W'(sq_p_reg) + SUM_W'(sq_q_reg) + NORM_K_SQ;
                root_reg <= '0;
                srem_reg <= '0;
                iter_reg <= '0;
                dsel_reg <= DSEL_X;
            end
            B_ROOT: begin
                rad_reg  <= {rad_reg[SUM_W-3:0], 2'b00};
                iter_reg <= iter_reg + ITER_W'(1);
                if (sq_ge) begin
                    srem_reg <= SREM_W'(sq_t - sq_trial);
                    root_reg <= {root_reg[ROOT_W-2:0], 1'b1};
                end else begin
                    srem_reg <= sq_t[SREM_W-1:0];
                    root_reg <= {root_reg[ROOT_W-2:0], 1'b0};
                end
            end
            B_DIV_SET: begin
                drem_reg <= DREM_W'(comp_num[NUM_W-1:QUOT_W]);
                dnum_reg <= comp_num[QUOT_W-1:0];
                den_reg  <= root_reg;
                iter_reg <= '0;
            end
            B_DIV: begin
                drem_reg <= div_ge ? DREM_W'(div_t - {1'b0, den_reg}) : div_t[DREM_W-1:0];
                dnum_reg <= {dnum_reg[QUOT_W-2:0], 1'b0};
                quot_reg <= quot_full;
                iter_reg <= iter_reg + ITER_W'(1);
                if (div_last) begin
                    unique case (dsel_reg)
                        DSEL_X: begin
                            nx_reg   <= comp_signed;
                            dsel_reg <= DSEL_Y;
                        end
                        DSEL_Y: begin
                            ny_reg   <= comp_signed;
                            dsel_reg <= DSEL_Z;
                        end
                        DSEL_Z: nz_reg <= comp_signed;
                        default: begin
                        end
                    endcase
                end
            end
            B_OUT: begin
                if (m_tready && !cur_b_reg && job_reg.emit_b) begin
                    cur_b_reg <= 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    // Result packing.
    assign row_out = cur_b_reg ? job_reg.y : job_reg.y - ROW_W'(1);
    assign m_tdata = {6'd0, nz_reg, ny_reg, nx_reg, height_reg, row_out, job_reg.x};
    assign m_tlast = cur_b_reg || !job_reg.emit_b;

    assert property (@(posedge aclk) disable iff (!aresetn) m_tvalid |-> !ny_reg[NORMAL_W-1])
        else $error("negative normal y component on output");
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == B_DIV) |-> (iter_reg < ITER_W'(DIV_STEPS)))
        else $error("divider ran past its last step");
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && cur_b_reg) |-> (nx_reg == '0 && nz_reg == '0))
        else $error("last-row result without border normal");

endmodule
